@@ hw/rtl/voice_filter_and_decay_envelope_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the voice filter and decay envelope
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef VOICE_FILTER_AND_DECAY_ENVELOPE_ASSERT_SVH
`define VOICE_FILTER_AND_DECAY_ENVELOPE_ASSERT_SVH
`ifndef SYNTHESIS
`define VFDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define VFDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VFDE_ASSERT(lbl, prop, msg)
`define VFDE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/vfde_pkg.sv @@
// ----------------------------------------------------------------------------
// vfde_pkg
// Widths, register indexes and shared types of the voice filter and envelope.
// ----------------------------------------------------------------------------
package vfde_pkg;

  localparam int unsigned SampleW     = 8;
  localparam int unsigned CoefW       = 16;
  localparam int unsigned AccW        = 16;
  localparam int unsigned StepW       = 17;
  localparam int unsigned EnvFracBits = 16;
  localparam int unsigned EnvPosW     = EnvFracBits + 1;
  localparam int unsigned EnvSumW     = ((EnvPosW > StepW) ? EnvPosW : StepW) + 1;
  localparam int unsigned ProdW       = SampleW + EnvPosW;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 17;
  localparam int unsigned FiltCntW    = $clog2(CoefW);
  localparam int unsigned VcaCntW     = $clog2(SampleW);

  localparam logic [EnvPosW-1:0] EnvOne    = EnvPosW'(1) << EnvFracBits;
  localparam logic [StepW-1:0]   StepReset = StepW'(65536);

  typedef enum logic [CfgIdxW-1:0] {
    CfgInputGain   = CfgIdxW'(0),
    CfgFeedbackOne = CfgIdxW'(1),
    CfgFeedbackTwo = CfgIdxW'(2),
    CfgEnvStep     = CfgIdxW'(3)
  } cfg_reg_e;

  typedef struct packed {
    logic start;
    logic gate;
  } vca_cmd_t;

endpackage

@@ hw/rtl/vfde_filter.sv @@
// ----------------------------------------------------------------------------
// vfde_filter
// Two-pole IIR, one coefficient bit per cycle over three shift-add lanes.
// ----------------------------------------------------------------------------
module vfde_filter import vfde_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic signed [CoefW-1:0]   gain_i,
  input  logic signed [CoefW-1:0]   fb_one_i,
  input  logic signed [CoefW-1:0]   fb_two_i,
  output logic                      done_o,
  output logic signed [SampleW-1:0] filt_o
);

  logic                busy_q;
  logic [FiltCntW-1:0] cnt_q;
  logic [CoefW-1:0]    c0_q, c1_q, c2_q;
  logic [AccW-1:0]     o0_q, o1_q, o2_q;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [SampleW-1:0]  y1_q, y2_q;
  logic                done_q;

  // Mod 2^16 the sign weight of the top coefficient bit does not matter.
  assign acc_d = acc_q + (c0_q[0] ? o0_q : AccW'(0))
                       + (c1_q[0] ? o1_q : AccW'(0))
                       + (c2_q[0] ? o2_q : AccW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      y1_q   <= '0;
      y2_q   <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == FiltCntW'(CoefW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + FiltCntW'(1);
        if (cnt_q == FiltCntW'(CoefW - 1)) begin
          busy_q <= 1'b0;
          y2_q   <= y1_q;
          y1_q   <= acc_d[AccW-1 -: SampleW];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      c0_q  <= gain_i;
      c1_q  <= fb_one_i;
      c2_q  <= fb_two_i;
      o0_q  <= {{(AccW-SampleW){sample_i[SampleW-1]}}, sample_i};
      o1_q  <= {{(AccW-SampleW){y1_q[SampleW-1]}}, y1_q};
      o2_q  <= {{(AccW-SampleW){y2_q[SampleW-1]}}, y2_q};
      acc_q <= '0;
    end else if (busy_q) begin
      c0_q  <= c0_q >> 1;
      c1_q  <= c1_q >> 1;
      c2_q  <= c2_q >> 1;
      o0_q  <= o0_q << 1;
      o1_q  <= o1_q << 1;
      o2_q  <= o2_q << 1;
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign filt_o = y1_q;

endmodule

@@ hw/rtl/vfde_vca.sv @@
// ----------------------------------------------------------------------------
// vfde_vca
// Linear decay envelope; sample scaling by a bit-serial shift-add multiply.
// ----------------------------------------------------------------------------
module vfde_vca import vfde_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  vca_cmd_t                  cmd_i,
  input  logic signed [SampleW-1:0] filt_i,
  input  logic [StepW-1:0]          step_i,
  output logic                      done_o,
  output logic signed [SampleW-1:0] voice_o,
  output logic                      armed_o
);

  logic                busy_q;
  logic [VcaCntW-1:0]  cnt_q;
  logic                gate_q, neg_q;
  logic [SampleW-1:0]  fs_q;
  logic [SampleW-1:0]  mplier_q;
  logic [ProdW-1:0]    mcand_q, prod_q, prod_d;
  logic [EnvPosW-1:0]  pos_q;
  logic                active_q;
  logic                done_q;
  logic [SampleW-1:0]  voice_q;
  logic [SampleW-1:0]  mag, scaled, signed_scaled;
  logic [EnvSumW-1:0]  pos_sum;
  logic [EnvPosW-1:0]  pos_next;

  assign mag    = filt_i[SampleW-1] ? (~filt_i + SampleW'(1)) : filt_i;
  assign prod_d = prod_q + (mplier_q[0] ? mcand_q : ProdW'(0));
  assign scaled = prod_d[EnvFracBits +: SampleW];
  assign signed_scaled = neg_q ? (~scaled + SampleW'(1)) : scaled;
  assign pos_sum  = EnvSumW'(pos_q) + EnvSumW'(step_i);
  assign pos_next = (pos_sum > EnvSumW'(EnvOne)) ? EnvOne : pos_sum[EnvPosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      pos_q    <= '0;
      active_q <= 1'b0;
    end else begin
      done_q <= !cmd_i.start && busy_q && (cnt_q == VcaCntW'(SampleW - 1));
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + VcaCntW'(1);
        if (cnt_q == VcaCntW'(SampleW - 1)) begin
          busy_q <= 1'b0;
          if (gate_q) begin
            pos_q    <= '0;
            active_q <= 1'b1;
          end else if (active_q) begin
            if (pos_q < EnvOne) begin
              pos_q <= pos_next;
            end else begin
              active_q <= 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      gate_q   <= cmd_i.gate;
      neg_q    <= filt_i[SampleW-1];
      fs_q     <= filt_i;
      mplier_q <= mag;
      mcand_q  <= ProdW'(EnvOne - pos_q);
      prod_q   <= '0;
    end else if (busy_q) begin
      mplier_q <= mplier_q >> 1;
      mcand_q  <= mcand_q << 1;
      prod_q   <= prod_d;
      if (cnt_q == VcaCntW'(SampleW - 1)) begin
        if (gate_q) begin
          voice_q <= fs_q;
        end else if (active_q && (pos_q < EnvOne)) begin
          voice_q <= signed_scaled;
        end else begin
          voice_q <= '0;
        end
      end
    end
  end

  assign done_o  = done_q;
  assign voice_o = voice_q;
  assign armed_o = active_q;

endmodule

@@ hw/rtl/voice_filter_and_decay_envelope.sv @@
// ----------------------------------------------------------------------------
// voice_filter_and_decay_envelope
// Resonant two-pole filter followed by a linear decay VCA, one item at a time.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries oscillator_sample_i and gate_i.
// Output channel out_valid_o/out_ready_i carries voice_sample_o and
// envelope_armed_o, one result item per input item, in order.
// Config channel cfg_valid_i/cfg_ready_o writes cfg_data_i to register
// cfg_index_i: 0 input gain, 1 feedback one, 2 feedback two, 3 envelope step.
// Write configuration only while no item is in flight.
// An item passes through the filter (one coefficient bit per cycle), then the
// VCA multiply (one sample magnitude bit per cycle), then the output register.
// A new item is taken only after the previous result enters the output register.
// The output register holds a finished result while the receiver stalls; the
// next item is already accepted and computed, and then waits for the register.
// Reset clears filter history and the envelope (not armed), zeroes the filter
// coefficients and sets the envelope step to 1.0.
// ----------------------------------------------------------------------------
`include "voice_filter_and_decay_envelope_assert.svh"

module voice_filter_and_decay_envelope import vfde_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] oscillator_sample_i,
  input  logic                      gate_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] voice_sample_o,
  output logic                      envelope_armed_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StFilt,
    StVca,
    StHold
  } state_e;

  state_e               state_q;
  logic                 gate_q;
  logic                 out_valid_q;
  logic [SampleW-1:0]   out_voice_q;
  logic                 out_armed_q;
  logic [CoefW-1:0]     gain_q, fb_one_q, fb_two_q;
  logic [StepW-1:0]     step_q;
  logic                 in_acc;
  logic                 filt_done, vca_done;
  logic [SampleW-1:0]   filt_out, vca_voice;
  logic                 vca_armed;
  logic                 out_free;
  logic                 out_load;
  vca_cmd_t             vca_cmd;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (((state_q == StVca) && vca_done) || (state_q == StHold)) && out_free;

  assign vca_cmd.start = filt_done;
  assign vca_cmd.gate  = gate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      fb_one_q <= '0;
      fb_two_q <= '0;
      step_q   <= StepReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgInputGain:   gain_q   <= cfg_data_i[CoefW-1:0];
        CfgFeedbackOne: fb_one_q <= cfg_data_i[CoefW-1:0];
        CfgFeedbackTwo: fb_two_q <= cfg_data_i[CoefW-1:0];
        CfgEnvStep:     step_q   <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      gate_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_voice_q <= '0;
      out_armed_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            gate_q  <= gate_i;
            state_q <= StFilt;
          end
        end
        StFilt: begin
          if (filt_done) begin
            state_q <= StVca;
          end
        end
        StVca, StHold: begin
          if (vca_done || (state_q == StHold)) begin
            if (out_free) begin
              out_voice_q <= vca_voice;
              out_armed_q <= vca_armed;
              state_q     <= StIdle;
            end else begin
              state_q <= StHold;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  vfde_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .sample_i (oscillator_sample_i),
    .gain_i   (gain_q),
    .fb_one_i (fb_one_q),
    .fb_two_i (fb_two_q),
    .done_o   (filt_done),
    .filt_o   (filt_out)
  );

  vfde_vca u_vca (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (vca_cmd),
    .filt_i  (filt_out),
    .step_i  (step_q),
    .done_o  (vca_done),
    .voice_o (vca_voice),
    .armed_o (vca_armed)
  );

  assign out_valid_o      = out_valid_q;
  assign voice_sample_o   = out_voice_q;
  assign envelope_armed_o = out_armed_q;

  `VFDE_ASSERT_NEXT(a_accept_busy, in_acc, !in_ready_o, "item taken while busy")
  `VFDE_ASSERT(a_filt_done_state, filt_done |-> (state_q == StFilt), "stray filter done")
  `VFDE_ASSERT(a_vca_done_state, vca_done |-> (state_q == StVca), "stray vca done")
  `VFDE_ASSERT(a_done_excl, $onehot0({filt_done, vca_done}), "filter and vca done together")

endmodule

@@ verif/voice_filter_and_decay_envelope_tb.sv @@
// ----------------------------------------------------------------------------
// voice_filter_and_decay_envelope_tb
// Drives sample/gate items through the resonant filter and decay VCA with
// bursty input and a stalling output, predicts every result with its own copy
// of filter history, envelope and registers, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module voice_filter_and_decay_envelope_tb;
  import vfde_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int PhaseItems = 225;
  localparam int ReleaseMax = 40;

  typedef struct {
    logic signed [SampleW-1:0] sample;
    logic                      gate;
  } note_item_t;

  typedef struct {
    logic signed [SampleW-1:0] sample;
    logic                      armed;
  } voice_result_t;

  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyCoinFlip,
    ReadySparse,
    ReadyPeriodic
  } ready_mode_e;

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] oscillator_sample_i = '0;
  logic                      gate_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [SampleW-1:0] voice_sample_o;
  logic                      envelope_armed_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i = '0;
  logic [CfgDataW-1:0]       cfg_data_i = '0;

  note_item_t    pending_items[$];
  voice_result_t expected_voice[$];
  int            items_total = 0;
  int            results_checked = 0;
  int            voice_mismatches = 0;
  int            cycle_count = 0;

  logic signed [CoefW-1:0]   gain_q8 = '0;
  logic signed [CoefW-1:0]   fb1_q8 = '0;
  logic signed [CoefW-1:0]   fb2_q8 = '0;
  logic [StepW-1:0]          env_step = StepReset;
  logic signed [SampleW-1:0] hist_last = '0;
  logic signed [SampleW-1:0] hist_older = '0;
  logic [EnvPosW-1:0]        env_pos = '0;
  logic                      env_armed = 1'b0;

  int          burst_left = 1;
  int          gap_left = 0;
  ready_mode_e ready_mode = ReadyAlways;
  int          mode_left = 0;

  voice_filter_and_decay_envelope dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .oscillator_sample_i,
    .gate_i,
    .out_valid_o,
    .out_ready_i,
    .voice_sample_o,
    .envelope_armed_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic voice_result_t filter_and_envelope(logic signed [SampleW-1:0] x,
                                                        logic gate_in);
    int                        acc;
    int                        prod;
    int                        shaped;
    logic signed [SampleW-1:0] filt;
    logic [EnvPosW:0]          next_pos;
    voice_result_t             r;
    acc = int'(gain_q8) * int'(x) + int'(fb1_q8) * int'(hist_last)
        + int'(fb2_q8) * int'(hist_older);
    filt = acc[15:8];
    hist_older = hist_last;
    hist_last = filt;
    shaped = 0;
    if (gate_in) begin
      env_pos = '0;
      env_armed = 1'b1;
      shaped = int'(filt);
    end else if (env_armed) begin
      if (env_pos < EnvOne) begin
        prod = int'(filt) * int'(EnvOne - env_pos);
        shaped = (prod >= 0) ? (prod >>> EnvFracBits) : -((-prod) >>> EnvFracBits);
        next_pos = {1'b0, env_pos} + {1'b0, env_step};
        env_pos = (next_pos > {1'b0, EnvOne}) ? EnvOne : next_pos[EnvPosW-1:0];
      end else begin
        env_armed = 1'b0;
      end
    end
    r.sample = shaped[SampleW-1:0];
    r.armed = env_armed;
    return r;
  endfunction

  function automatic logic signed [SampleW-1:0] random_sample();
    case ($urandom_range(0, 15))
      0: return 8'sd127;
      1: return -8'sd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_item(logic signed [SampleW-1:0] sample, logic gate);
    note_item_t item;
    item.sample = sample;
    item.gate = gate;
    pending_items.push_back(item);
    items_total++;
  endtask

  // Mostly well-formed notes (hold, then release), the rest random gate noise.
  task automatic queue_notes(int count);
    int added;
    int hold;
    int rel;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 4) != 0) begin
        hold = $urandom_range(1, 6);
        rel = $urandom_range(0, ReleaseMax);
        repeat (hold) add_item(random_sample(), 1'b1);
        repeat (rel) add_item(random_sample(), 1'b0);
        added += hold + rel;
      end else begin
        hold = $urandom_range(1, 10);
        repeat (hold) add_item(random_sample(), 1'($urandom_range(0, 1)));
        added += hold;
      end
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
    cfg_index_i <= idx;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgInputGain:   gain_q8 = value[CoefW-1:0];
      CfgFeedbackOne: fb1_q8 = value[CoefW-1:0];
      CfgFeedbackTwo: fb2_q8 = value[CoefW-1:0];
      CfgEnvStep:     env_step = value[StepW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_voice(int gain, int fb1, int fb2, int step);
    write_reg(CfgInputGain, CfgDataW'(gain));
    write_reg(CfgFeedbackOne, CfgDataW'(fb1));
    write_reg(CfgFeedbackTwo, CfgDataW'(fb2));
    write_reg(CfgEnvStep, CfgDataW'(step));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain(int settle);
    while (results_checked < items_total) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      oscillator_sample_i <= '0;
      gate_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        oscillator_sample_i <= pending_items[0].sample;
        gate_i <= pending_items[0].gate;
        in_valid_i <= 1'b1;
        void'(pending_items.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        ReadyAlways:   out_ready_i <= 1'b1;
        ReadyCoinFlip: out_ready_i <= 1'($urandom_range(0, 1));
        ReadySparse:   out_ready_i <= ($urandom_range(0, 15) == 0);
        ReadyPeriodic: out_ready_i <= ((cycle_count % 32) < 20);
        default:       out_ready_i <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    voice_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_voice.push_back(filter_and_envelope(oscillator_sample_i, gate_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_voice.size() == 0) begin
          $error("unexpected item: voice_sample %0d envelope_armed %0b",
                 voice_sample_o, envelope_armed_o);
          voice_mismatches++;
        end else begin
          want = expected_voice.pop_front();
          if (voice_sample_o !== want.sample) begin
            $error("voice_sample: expected %0d, actual %0d", want.sample, voice_sample_o);
            voice_mismatches++;
          end
          if (envelope_armed_o !== want.armed) begin
            $error("envelope_armed: expected %0b, actual %0b", want.armed,
                   envelope_armed_o);
            voice_mismatches++;
          end
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int phase_steps[8];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: silent filter, released while not armed, step of one.
    add_item(8'sd127, 1'b0);
    add_item(-8'sd128, 1'b1);
    add_item(8'sd0, 1'b0);
    add_item(-8'sd1, 1'b0);
    add_item(8'sd1, 1'b0);
    drain(8);

    // Unity gain, quarter step: negative truncation toward zero, disarm.
    set_voice(256, 0, 0, 16384);
    add_item(8'sd127, 1'b1);
    add_item(-8'sd128, 1'b0);
    add_item(-8'sd128, 1'b0);
    add_item(8'sd127, 1'b0);
    add_item(-8'sd1, 1'b0);
    add_item(-8'sd128, 1'b0);
    add_item(8'sd5, 1'b0);
    drain(8);

    // Extreme coefficients with wrap, zero step holds full scale.
    set_voice(-32768, 32767, -32768, 0);
    add_item(8'sd127, 1'b1);
    add_item(-8'sd128, 1'b0);
    add_item(8'sd127, 1'b0);
    add_item(-8'sd1, 1'b0);
    add_item(8'sd0, 1'b1);
    add_item(-8'sd128, 1'b0);
    drain(8);

    // Opposite extremes, step above one saturates at once.
    set_voice(32767, -32768, 32767, 'h1FFFF);
    add_item(-8'sd128, 1'b1);
    add_item(8'sd127, 1'b0);
    add_item(8'sd127, 1'b0);
    add_item(8'sd0, 1'b0);
    add_item(-8'sd128, 1'b1);
    drain(8);

    phase_steps = '{4096, 0, 1, 'h1FFFF, 65535, 65536,
                    $urandom_range(1024, 16384), $urandom_range(0, 'h1FFFF)};
    foreach (phase_steps[ph]) begin
      if (ph % 2 == 0) begin
        set_voice(int'($urandom_range(0, 1023)) - 512, int'($urandom_range(0, 1023)) - 512,
                  int'($urandom_range(0, 511)) - 256, phase_steps[ph]);
      end else begin
        set_voice($urandom, $urandom, $urandom, phase_steps[ph]);
      end
      queue_notes(PhaseItems);
      drain(8);
    end

    drain(40);
    if (voice_mismatches == 0 && expected_voice.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
